// ===== hw/rtl/cnbc_pkg.sv =====
`default_nettype none

package cnbc_pkg;

    localparam int MAX_LEN = 65536;
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    localparam int MOD_W = 63;
    localparam int LIM_W = 32;
    localparam int BND_W = 64;
    localparam int DATA_W = 64;
    localparam int IDX_W = 2;
    localparam int SUM_W = 81;
    localparam int BSQ_W = 82;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_RANGE_LIMIT = 2'd1;
    localparam logic [IDX_W-1:0] REG_BOUND = 2'd2;
    localparam logic [IDX_W-1:0] REG_NORM_KIND = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    localparam logic NORM_L2 = 1'b0;

    typedef struct packed {
        logic [MOD_W-1:0] modulus;
        logic [LIM_W-1:0] range_limit;
        logic [BND_W-1:0] bound_value;
        logic             norm_kind;
    } cnbc_cfg_t;

    typedef struct packed {
        logic [LIM_W-1:0] mag;
        logic             acc;
        logic             last;
        logic [1:0]       status;
    } cnbc_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cnbc_front.sv =====
`default_nettype none

module cnbc_front
    import cnbc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cnbc_cfg_t        cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [MOD_W-1:0] element,
    input  wire logic             last,
    output logic                  push,
    output cnbc_entry_t           push_data,
    input  wire logic             push_ready
);

    logic             s1_valid_reg;
    logic             s1_hi_nz_reg;
    logic [LIM_W-1:0] s1_mag_reg;
    logic             s1_last_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [1:0]       err_reg;
    logic [1:0]       err_next;

    logic [MOD_W-1:0] half;
    logic [63:0]      mag_full;
    logic             accept;
    logic             over;
    logic             range_fail;
    logic             acc;

    assign in_ready = !s1_valid_reg || push_ready;
    assign accept = in_valid && in_ready;
    assign push = s1_valid_reg && push_ready;

    always_comb
    begin
        half = cfg.modulus >> 1;
        if (element > half)
        begin
            mag_full = {1'b0, cfg.modulus} - {1'b0, element};
        end
        else
        begin
            mag_full = {1'b0, element};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hi_nz_reg <= |mag_full[63:LIM_W];
            s1_mag_reg <= mag_full[LIM_W-1:0];
            s1_last_reg <= last;
        end
    end

    // The first error of a vector is kept; after it elements are counted only.
    always_comb
    begin
        over = cnt_reg >= CNT_W'(MAX_LEN);
        range_fail = s1_hi_nz_reg || (s1_mag_reg >= cfg.range_limit);
        cnt_next = cnt_reg;
        err_next = err_reg;
        acc = 1'b0;
        if (over)
        begin
            if (err_reg == ST_OK)
            begin
                err_next = ST_LONG;
            end
        end
        else
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (err_reg == ST_OK)
            begin
                if (range_fail)
                begin
                    err_next = ST_RANGE;
                end
                else
                begin
                    acc = 1'b1;
                end
            end
        end
        push_data.mag = s1_mag_reg;
        push_data.acc = acc;
        push_data.last = s1_last_reg;
        push_data.status = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= ST_OK;
        end
        else if (push)
        begin
            if (s1_last_reg)
            begin
                cnt_reg <= '0;
                err_reg <= ST_OK;
            end
            else
            begin
                cnt_reg <= cnt_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cnbc_fifo.sv =====
`default_nettype none

module cnbc_fifo
    import cnbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire cnbc_entry_t push_data,
    output logic             push_ready,
    input  wire logic        pop,
    output cnbc_entry_t      head,
    output logic             head_valid
);

    cnbc_entry_t      store_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign push_ready = count_reg != (PTR_W + 1)'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cnbc_back.sv =====
`default_nettype none

module cnbc_back
    import cnbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cnbc_cfg_t   cfg,
    input  wire logic        bound_wr,
    input  wire cnbc_entry_t head,
    input  wire logic        head_valid,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             within_bound,
    output logic [1:0]       status
);

    localparam logic [1:0] BSQ_IDLE = 2'd0;
    localparam logic [1:0] BSQ_ADD2 = 2'd1;
    localparam logic [1:0] BSQ_ADD1 = 2'd2;
    localparam logic [1:0] BSQ_MUL = 2'd3;

    logic             b1_valid_reg;
    logic [63:0]      b1_sq_reg;
    logic [LIM_W-1:0] b1_mag_reg;
    logic             b1_acc_reg;
    logic             b1_last_reg;
    logic [1:0]       b1_status_reg;

    logic [SUM_W-1:0] sum_reg;
    logic [LIM_W-1:0] max_reg;

    logic             fin_valid_reg;
    logic [SUM_W-1:0] fin_sum_reg;
    logic [LIM_W-1:0] fin_max_reg;
    logic [1:0]       fin_status_reg;

    logic             out_valid_reg;
    logic             out_within_reg;
    logic [1:0]       out_status_reg;

    logic [1:0]       bsq_state_reg;
    logic [63:0]      p_ll_reg;
    logic [40:0]      p_lh_reg;
    logic [17:0]      p_hh_reg;
    logic [BSQ_W-1:0] bsq_reg;
    logic             bsq_sat_reg;

    logic             bsq_busy;
    logic             fin_adv;
    logic             fin_free;
    logic             b1_adv;
    logic             b1_load;
    logic [SUM_W-1:0] sum_acc;
    logic [LIM_W-1:0] max_acc;
    logic             l2_ok;
    logic             linf_ok;
    logic             bound_met;

    assign bsq_busy = bsq_state_reg != BSQ_IDLE;
    assign fin_adv = fin_valid_reg && !bsq_busy && (!out_valid_reg || out_ready);
    assign fin_free = !fin_valid_reg || fin_adv;
    assign b1_adv = b1_valid_reg && (!b1_last_reg || fin_free);
    assign b1_load = !b1_valid_reg || b1_adv;
    assign pop = head_valid && b1_load;

    assign out_valid = out_valid_reg;
    assign within_bound = out_within_reg;
    assign status = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else if (b1_load)
        begin
            b1_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_sq_reg <= {32'b0, head.mag} * {32'b0, head.mag};
            b1_mag_reg <= head.mag;
            b1_acc_reg <= head.acc;
            b1_last_reg <= head.last;
            b1_status_reg <= head.status;
        end
    end

    always_comb
    begin
        sum_acc = sum_reg;
        max_acc = max_reg;
        if (b1_acc_reg)
        begin
            sum_acc = sum_reg + SUM_W'(b1_sq_reg);
            if (b1_mag_reg > max_reg)
            begin
                max_acc = b1_mag_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            max_reg <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_adv)
            begin
                if (b1_last_reg)
                begin
                    sum_reg <= '0;
                    max_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_acc;
                    max_reg <= max_acc;
                end
            end
            if (b1_adv && b1_last_reg)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_adv)
            begin
                fin_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_adv && b1_last_reg)
        begin
            fin_sum_reg <= sum_acc;
            fin_max_reg <= max_acc;
            fin_status_reg <= b1_status_reg;
        end
    end

    // The square of the bound is rebuilt from three partial products after each write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsq_state_reg <= BSQ_IDLE;
            bsq_reg <= '0;
            bsq_sat_reg <= 1'b0;
        end
        else if (bound_wr)
        begin
            bsq_state_reg <= BSQ_MUL;
        end
        else
        begin
            unique case (bsq_state_reg)
                BSQ_MUL:
                begin
                    bsq_sat_reg <= |cfg.bound_value[BND_W-1:41];
                    bsq_state_reg <= BSQ_ADD1;
                end
                BSQ_ADD1:
                begin
                    bsq_reg <= BSQ_W'(p_ll_reg) + (BSQ_W'(p_lh_reg) << 33);
                    bsq_state_reg <= BSQ_ADD2;
                end
                BSQ_ADD2:
                begin
                    bsq_reg <= bsq_reg + (BSQ_W'(p_hh_reg) << 64);
                    bsq_state_reg <= BSQ_IDLE;
                end
                BSQ_IDLE:
                begin
                    bsq_state_reg <= BSQ_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (bsq_state_reg == BSQ_MUL)
        begin
            p_ll_reg <= {32'b0, cfg.bound_value[31:0]} * {32'b0, cfg.bound_value[31:0]};
            p_lh_reg <= {9'b0, cfg.bound_value[31:0]} * {32'b0, cfg.bound_value[40:32]};
            p_hh_reg <= {9'b0, cfg.bound_value[40:32]} * {9'b0, cfg.bound_value[40:32]};
        end
    end

    always_comb
    begin
        l2_ok = bsq_sat_reg || ({1'b0, fin_sum_reg} < bsq_reg);
        linf_ok = (|cfg.bound_value[BND_W-1:LIM_W])
                  || (fin_max_reg < cfg.bound_value[LIM_W-1:0]);
        if (fin_status_reg != ST_OK)
        begin
            bound_met = 1'b0;
        end
        else if (cfg.norm_kind == NORM_L2)
        begin
            bound_met = l2_ok;
        end
        else
        begin
            bound_met = linf_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_adv)
        begin
            out_within_reg <= bound_met;
            out_status_reg <= fin_status_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> !within_bound)
        else $error("Failed vector reported as within bound.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_LONG))
        else $error("Result carries an undefined status.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (b1_adv && b1_last_reg) |=> (sum_reg == '0 && max_reg == '0))
        else $error("Vector state not cleared after the last element.");

endmodule

`default_nettype wire

// ===== hw/rtl/centered_norm_bound_check_unit.sv =====
`default_nettype none

// Checks the centered L2 or L-infinity norm of a stream of field-element vectors, one
// element per clock cycle while results are taken and the queue has room, and raises
// one result per vector after its last element is accepted; the front stage centres and
// range-checks each element, a four-entry queue decouples it from the back stage, which
// squares (one 32 by 32 multiplier) and accumulates the 81-bit sum. A write to the bound
// register starts a rebuild of the squared bound (multiply, then two add steps), during
// which results are held back while elements continue to be accepted.

module centered_norm_bound_check_unit
    import cnbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [MOD_W-1:0]  element,
    input  wire logic              last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   within_bound,
    output logic [1:0]             status
);

    cnbc_cfg_t   cfg_reg;
    logic        bound_wr_reg;
    logic        push;
    logic        push_ready;
    cnbc_entry_t push_data;
    logic        pop;
    cnbc_entry_t head;
    logic        head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus <= MOD_W'(1);
            cfg_reg.range_limit <= '0;
            cfg_reg.bound_value <= '0;
            cfg_reg.norm_kind <= NORM_L2;
            bound_wr_reg <= 1'b0;
        end
        else
        begin
            bound_wr_reg <= cfg_we && (cfg_index == REG_BOUND);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODULUS:     cfg_reg.modulus <= cfg_data[MOD_W-1:0];
                    REG_RANGE_LIMIT: cfg_reg.range_limit <= cfg_data[LIM_W-1:0];
                    REG_BOUND:       cfg_reg.bound_value <= cfg_data[BND_W-1:0];
                    REG_NORM_KIND:   cfg_reg.norm_kind <= cfg_data[0];
                endcase
            end
        end
    end

    cnbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .element    (element),
        .last       (last),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    cnbc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    cnbc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .bound_wr     (bound_wr_reg),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .within_bound (within_bound),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== dv/tb_centered_norm_bound_check_unit.sv =====
`timescale 1ns / 1ps

module tb_centered_norm_bound_check_unit;
    import cnbc_pkg::*;

    localparam int SETTLE = 24;
    localparam int HOLD_OFF = 400;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int WIDE_LEN = 200;
    localparam logic NORM_LINF = ~NORM_L2;
    localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};
    localparam logic [LIM_W-1:0] LIM_MAX = {LIM_W{1'b1}};
    localparam logic [BND_W-1:0] BND_MAX = {BND_W{1'b1}};

    typedef struct packed {
        logic       in_bound;
        logic [1:0] status;
    } verdict_t;

    typedef struct packed {
        bit                is_write;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] data;
        logic [MOD_W-1:0]  elem;
        logic              tail;
        bit                fixed;
        verdict_t          answer;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [MOD_W-1:0]  element = '0;
    logic              last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              within_bound;
    logic [1:0]        status;

    logic [MOD_W-1:0]  shadow_modulus;
    logic [LIM_W-1:0]  shadow_limit;
    logic [BND_W-1:0]  shadow_bound;
    logic              shadow_kind;
    logic [SUM_W-1:0]  vec_sum;
    logic [LIM_W-1:0]  vec_max;
    logic [1:0]        vec_error;
    logic [CNT_W-1:0]  vec_count;

    verdict_t  verdicts_due[$];
    plan_row_t plan[$];
    int        faults = 0;
    int        verdicts_seen = 0;
    int        burst_left = 0;
    bit        steady = 1'b0;

    centered_norm_bound_check_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .element      (element),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .within_bound (within_bound),
        .status       (status)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] rand_upto(input logic [63:0] n);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (n == 64'hFFFF_FFFF_FFFF_FFFF)
            return r;
        return r % (n + 64'd1);
    endfunction

    function automatic bit fold_element(input logic [MOD_W-1:0] e, input logic tail,
                                        output verdict_t v);
        logic [63:0]  mag;
        logic [63:0]  sq;
        logic [127:0] bound_sq;
        mag = {1'b0, e};
        if (e > (shadow_modulus >> 1))
            mag = {1'b0, shadow_modulus} - {1'b0, e};
        if (vec_count >= MAX_LEN)
        begin
            if (vec_error == ST_OK)
                vec_error = ST_LONG;
        end
        else
        begin
            vec_count = vec_count + 1'b1;
            if (vec_error == ST_OK)
            begin
                if (mag >= {32'b0, shadow_limit})
                    vec_error = ST_RANGE;
                else
                begin
                    sq = {32'b0, mag[31:0]} * {32'b0, mag[31:0]};
                    vec_sum = vec_sum + {{(SUM_W-64){1'b0}}, sq};
                    if (mag[31:0] > vec_max)
                        vec_max = mag[31:0];
                end
            end
        end
        v = '0;
        if (!tail)
            return 1'b0;
        bound_sq = {64'b0, shadow_bound} * {64'b0, shadow_bound};
        v.status = vec_error;
        if (vec_error == ST_OK)
        begin
            if (shadow_kind == NORM_L2)
                v.in_bound = {{(128-SUM_W){1'b0}}, vec_sum} < bound_sq;
            else
                v.in_bound = {32'b0, vec_max} < shadow_bound;
        end
        vec_sum = '0;
        vec_max = '0;
        vec_error = ST_OK;
        vec_count = '0;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODULUS:     shadow_modulus = value[MOD_W-1:0];
            REG_RANGE_LIMIT: shadow_limit = value[LIM_W-1:0];
            REG_BOUND:       shadow_bound = value;
            REG_NORM_KIND:   shadow_kind = value[0];
            default:         ;
        endcase
    endtask

    task automatic send_element(input logic [MOD_W-1:0] e, input logic tail,
                                input bit fixed, input verdict_t answer);
        verdict_t v;
        int       gap;
        if (!steady && burst_left == 0)
        begin
            gap = $urandom_range(0, 7);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        element <= e;
        last <= tail;
        do
            @(posedge clk);
        while (!in_ready);
        if (fold_element(e, tail, v))
            verdicts_due.push_back(fixed ? answer : v);
    endtask

    task automatic plan_item(input logic [MOD_W-1:0] e, input logic tail, input bit fixed,
                             input logic in_bound, input logic [1:0] st);
        plan_row_t r;
        r = '0;
        r.elem = e;
        r.tail = tail;
        r.fixed = fixed;
        r.answer.in_bound = in_bound;
        r.answer.status = st;
        plan.push_back(r);
    endtask

    task automatic plan_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        plan_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.index = idx;
        r.data = value;
        plan.push_back(r);
    endtask

    // The receiver stalls in stretches of its own and, once, refuses results for a long
    // time so that the block backs up and stops taking requests.
    initial
    begin : receiver
        int  mode;
        int  stretch;
        bit  held;
        held = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            stretch = $urandom_range(20, 200);
            repeat (stretch)
            begin
                @(posedge clk);
                if (!held && verdicts_seen >= 40)
                begin
                    held = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF) @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            verdicts_seen++;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected result within_bound=%0d status=%0d",
                         $time, within_bound, status);
                faults++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (within_bound !== want.in_bound)
                begin
                    $display("%0t: within_bound expected %0d, actual %0d",
                             $time, want.in_bound, within_bound);
                    faults++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, status);
                    faults++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [63:0]      q;
        logic [63:0]      lim;
        logic [63:0]      half;
        logic [63:0]      cap;
        logic [63:0]      mag;
        logic [63:0]      bnd;
        logic [MOD_W-1:0] e;
        bit               has_cap;
        int               len;
        int               bad;
        int               count;

        shadow_modulus = 1;
        shadow_limit = '0;
        shadow_bound = '0;
        shadow_kind = NORM_L2;
        vec_sum = '0;
        vec_max = '0;
        vec_error = ST_OK;
        vec_count = '0;

        plan_item(0, 1'b1, 1'b1, 1'b0, ST_RANGE);
        plan_write(REG_MODULUS, 64'd97);
        plan_write(REG_RANGE_LIMIT, 64'd9);
        plan_write(REG_BOUND, 64'd10);
        plan_item(3, 1'b0, 1'b0, 1'b0, ST_OK);
        plan_item(94, 1'b0, 1'b0, 1'b0, ST_OK);
        plan_item(96, 1'b1, 1'b0, 1'b0, ST_OK);
        plan_item(49, 1'b0, 1'b0, 1'b0, ST_OK);
        plan_item(1, 1'b1, 1'b1, 1'b0, ST_RANGE);
        plan_item(200, 1'b1, 1'b1, 1'b0, ST_RANGE);
        plan_item(MOD_MAX, 1'b1, 1'b1, 1'b0, ST_RANGE);
        plan_item(8, 1'b0, 1'b0, 1'b0, ST_OK);
        plan_item(89, 1'b1, 1'b0, 1'b0, ST_OK);
        plan_write(REG_NORM_KIND, {{(DATA_W-1){1'b0}}, NORM_LINF});
        plan_write(REG_BOUND, 64'd9);
        plan_item(8, 1'b1, 1'b0, 1'b0, ST_OK);
        plan_item(5, 1'b0, 1'b0, 1'b0, ST_OK);
        plan_write(REG_MODULUS, 64'd0);
        plan_item(0, 1'b1, 1'b0, 1'b0, ST_OK);
        plan_item(1, 1'b1, 1'b1, 1'b0, ST_RANGE);
        plan_write(REG_MODULUS, {1'b0, MOD_MAX});
        plan_write(REG_RANGE_LIMIT, {32'b0, LIM_MAX});
        plan_write(REG_BOUND, BND_MAX);
        plan_write(REG_NORM_KIND, {{(DATA_W-1){1'b0}}, NORM_L2});
        plan_item(63'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, ST_OK);
        plan_item(MOD_MAX - 63'hFFFF_FFFE, 1'b1, 1'b0, 1'b0, ST_OK);
        plan_item(63'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, ST_RANGE);
        plan_write(REG_BOUND, 64'd0);
        plan_item(0, 1'b1, 1'b1, 1'b0, ST_OK);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
                write_reg(plan[i].index, plan[i].data);
            else
                send_element(plan[i].elem, plan[i].tail, plan[i].fixed, plan[i].answer);
        end

        // A long vector of large magnitudes carries the sum well beyond 64 bits.
        bnd = (64'd1 << 35) + rand_upto((64'd1 << 35) - 64'd1);
        write_reg(REG_BOUND, bnd);
        steady = 1'b1;
        for (int i = 0; i < WIDE_LEN; i++)
        begin
            mag = {32'b0, $urandom_range(32'hFFFF_FFFE, 32'h8000_0000)};
            e = i[0] ? MOD_MAX - mag[MOD_W-1:0] : mag[MOD_W-1:0];
            send_element(e, i == WIDE_LEN - 1, 1'b0, '0);
        end
        steady = 1'b0;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 6)
                0:       q = $urandom_range(2, 1000);
                1:       q = {32'b0, $urandom};
                2:       q = rand_upto({1'b0, MOD_MAX});
                3:       q = {1'b0, MOD_MAX};
                4:       q = $urandom_range(0, 1);
                default: q = rand_upto(64'hFFFF_FFFF_FFFF);
            endcase
            if (phase == 4)
                lim = 64'd0;
            else if (phase == 3)
                lim = {32'b0, LIM_MAX};
            else
                case ($urandom_range(0, 2))
                    0:       lim = {32'b0, LIM_MAX};
                    1:       lim = {32'b0, $urandom};
                    default: lim = $urandom_range(1, 200);
                endcase
            half = (q == 0) ? 64'd0 : (q - 64'd1) >> 1;
            has_cap = (lim != 0);
            cap = (lim - 64'd1 < half) ? lim - 64'd1 : half;
            if (phase == 5)
                bnd = BND_MAX;
            else if (phase == 2)
                bnd = 64'd0;
            else
                bnd = rand_upto(3 * cap + 64'd3);
            write_reg(REG_MODULUS, q);
            write_reg(REG_RANGE_LIMIT, lim);
            write_reg(REG_BOUND, bnd);
            write_reg(REG_NORM_KIND, {{(DATA_W-1){1'b0}}, phase[0] ? NORM_LINF : NORM_L2});

            count = 0;
            while (count < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
                for (int k = 0; k < len; k++)
                begin
                    if (k == bad || !has_cap)
                    begin
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                mag = rand_upto({1'b0, MOD_MAX});
                                e = mag[MOD_W-1:0];
                            end
                            1:       e = q[MOD_W-1:0] + $urandom_range(0, 50);
                            default: e = lim[MOD_W-1:0];
                        endcase
                    end
                    else
                    begin
                        if ($urandom_range(0, 3) == 0)
                            mag = cap - rand_upto((cap < 3) ? cap : 64'd3);
                        else
                            mag = rand_upto(cap);
                        if ($urandom_range(0, 1) == 1 && mag != 0)
                            e = q[MOD_W-1:0] - mag[MOD_W-1:0];
                        else
                            e = mag[MOD_W-1:0];
                    end
                    send_element(e, k == len - 1, 1'b0, '0);
                    count++;
                end
            end
        end

        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (faults == 0)
            $display("tb_centered_norm_bound_check_unit: done, clean");
        else
            $display("tb_centered_norm_bound_check_unit: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("tb_centered_norm_bound_check_unit: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cnbc_pkg.sv
hw/rtl/cnbc_front.sv
hw/rtl/cnbc_fifo.sv
hw/rtl/cnbc_back.sv
hw/rtl/centered_norm_bound_check_unit.sv
dv/tb_centered_norm_bound_check_unit.sv
